// ===== hw/rtl/sbps_pkg.sv =====
// Shared types, constants and lookup functions for the sweeping beam pixel shader.
// Depends on nothing; all files in hw/rtl but sbps_checker import this package.
package sbps_pkg;

    // Panel size
    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 384;

    // Pipeline depth, split over the three datapath modules
    localparam int GEOM_STAGES  = 4;
    localparam int DIV_STAGES   = 7;
    localparam int SHADE_STAGES = 3;
    localparam int PIPE_STAGES  = GEOM_STAGES + DIV_STAGES + SHADE_STAGES;

    // Configuration register indexes
    localparam logic [1:0] REG_HOUR   = 2'd0;
    localparam logic [1:0] REG_MINUTE = 2'd1;

    // Cycles to hold input off after a register write, while the angle recomputes
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Geometry result handed to the divider
    typedef struct packed {
        logic       inb;    // inside the cone
        logic [5:0] off;    // absolute offset across the axis
        logic [5:0] lim;    // cone half width at this projection
        logic [6:0] reach;  // along*100/230
        logic [6:0] near;   // (70-along)*100/70 near the hub, else 0
    } geom_t;

    // Side data that travels through the divider
    typedef struct packed {
        logic       inb;
        logic [6:0] reach;
        logic [6:0] near;
    } side_t;

    // Divider result handed to the shading stages
    typedef struct packed {
        logic       inb;
        logic [6:0] edge_q;
        logic [6:0] reach;
        logic [6:0] near;
    } divres_t;

    // Quarter-wave table, scaled by 1024, used as given
    function automatic logic [9:0] quarter_wave(input logic [5:0] idx);
        logic [9:0] v;
        case (idx)
            6'd0:  v = 10'd0;   6'd1:  v = 10'd25;  6'd2:  v = 10'd50;  6'd3:  v = 10'd75;
            6'd4:  v = 10'd100; 6'd5:  v = 10'd125; 6'd6:  v = 10'd150; 6'd7:  v = 10'd175;
            6'd8:  v = 10'd199; 6'd9:  v = 10'd224; 6'd10: v = 10'd248; 6'd11: v = 10'd272;
            6'd12: v = 10'd296; 6'd13: v = 10'd320; 6'd14: v = 10'd343; 6'd15: v = 10'd366;
            6'd16: v = 10'd389; 6'd17: v = 10'd412; 6'd18: v = 10'd434; 6'd19: v = 10'd456;
            6'd20: v = 10'd477; 6'd21: v = 10'd499; 6'd22: v = 10'd519; 6'd23: v = 10'd540;
            6'd24: v = 10'd560; 6'd25: v = 10'd579; 6'd26: v = 10'd598; 6'd27: v = 10'd616;
            6'd28: v = 10'd634; 6'd29: v = 10'd651; 6'd30: v = 10'd668; 6'd31: v = 10'd684;
            6'd32: v = 10'd700; 6'd33: v = 10'd715; 6'd34: v = 10'd730; 6'd35: v = 10'd744;
            6'd36: v = 10'd757; 6'd37: v = 10'd770; 6'd38: v = 10'd782; 6'd39: v = 10'd793;
            6'd40: v = 10'd804; 6'd41: v = 10'd814; 6'd42: v = 10'd824; 6'd43: v = 10'd833;
            6'd44: v = 10'd841; 6'd45: v = 10'd848; 6'd46: v = 10'd855; 6'd47: v = 10'd861;
            6'd48: v = 10'd866; 6'd49: v = 10'd871; 6'd50: v = 10'd875; 6'd51: v = 10'd878;
            6'd52: v = 10'd881; 6'd53: v = 10'd883; 6'd54: v = 10'd884; 6'd55: v = 10'd885;
            6'd56: v = 10'd885; 6'd57: v = 10'd884; 6'd58: v = 10'd883; 6'd59: v = 10'd881;
            6'd60: v = 10'd878; 6'd61: v = 10'd875; 6'd62: v = 10'd871; 6'd63: v = 10'd866;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    // Sine over 256 steps per turn, built from the quarter wave
    function automatic logic signed [10:0] wave_sin(input logic [7:0] step);
        logic [9:0] mag;
        mag = step[6] ? quarter_wave(~step[5:0]) : quarter_wave(step[5:0]);
        return step[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// ===== hw/rtl/sbps_geom.sv =====
// Geometry stages: hub offsets, rotation products, projection, cone test and
// falloff ratios. Depends on sbps_pkg.
module sbps_geom (
    input  logic                                   clk,
    input  logic [sbps_pkg::GEOM_STAGES-1:0]       en,
    input  logic [9:0]                             pixel_x,
    input  logic [8:0]                             pixel_y,
    input  logic signed [10:0]                     ax,
    input  logic signed [10:0]                     ay,
    output sbps_pkg::geom_t                        geom
);
    import sbps_pkg::*;

    logic                offp_reg;
    logic signed [10:0]  dx_reg;
    logic signed [9:0]   dy_reg;
    logic                offq_reg;
    logic signed [21:0]  pxa_reg, pya_reg, pxy_reg, pyx_reg;
    logic                offr_reg;
    logic signed [12:0]  along_reg, across_reg;
    geom_t               geom_reg, geom_next;

    logic signed [22:0]  sum_a, sum_c;
    logic signed [22:0]  adj_a, adj_c;

    // Stage 1: off-panel check and offsets from the hub
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            offp_reg <= (32'(pixel_x) >= IMAGE_WIDTH) || (32'(pixel_y) >= IMAGE_HEIGHT);
            dx_reg   <= $signed({1'b0, pixel_x}) - 11'sd262;
            dy_reg   <= $signed({1'b0, pixel_y}) - 10'sd116;
        end
    end

    // Stage 2: rotation products
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            offq_reg <= offp_reg;
            pxa_reg  <= 22'(22'(dx_reg) * 22'(ax));
            pya_reg  <= 22'(22'(dy_reg) * 22'(ay));
            pxy_reg  <= 22'(22'(dx_reg) * 22'(ay));
            pyx_reg  <= 22'(22'(dy_reg) * 22'(ax));
        end
    end

    // Stage 3: sums, divided by 1024 toward zero
    always_comb
    begin
        sum_a = 23'(pxa_reg) + 23'(pya_reg);
        sum_c = 23'(pxy_reg) - 23'(pyx_reg);
        adj_a = sum_a + (sum_a < 0 ? 23'sd1023 : 23'sd0);
        adj_c = sum_c + (sum_c < 0 ? 23'sd1023 : 23'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            offr_reg   <= offq_reg;
            along_reg  <= 13'(adj_a >>> 10);
            across_reg <= 13'(adj_c >>> 10);
        end
    end

    // Stage 4: cone test, half width and falloff ratios
    always_comb
    begin
        logic [7:0]  a8;
        logic [15:0] lim_w;
        logic [30:0] reach_w;
        logic [6:0]  nd;
        logic [26:0] near_w;
        logic [12:0] mag;
        logic        ok;
        a8      = along_reg[7:0];
        lim_w   = 16'(a8) * 16'd260;
        reach_w = 31'(a8) * 31'd7294500;
        nd      = 7'd70 - a8[6:0];
        near_w  = 27'(nd) * 27'd1498000;
        mag     = across_reg < 0 ? 13'(-across_reg) : 13'(across_reg);
        ok      = !offr_reg && (along_reg >= 13'sd22) && (along_reg <= 13'sd230);
        geom_next.lim   = lim_w[15:10];
        geom_next.inb   = ok && (mag <= 13'(lim_w[15:10]));
        geom_next.off   = mag[5:0];
        geom_next.reach = reach_w[30:24];
        geom_next.near  = (along_reg < 13'sd70) ? near_w[26:20] : 7'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

// ===== hw/rtl/sbps_div.sv =====
// Pipelined restoring divider for the edge ratio off*100/lim, one quotient
// bit per stage. Depends on sbps_pkg.
module sbps_div (
    input  logic                                 clk,
    input  logic [sbps_pkg::DIV_STAGES-1:0]      en,
    input  sbps_pkg::geom_t                      geom,
    output sbps_pkg::divres_t                    res
);
    import sbps_pkg::*;

    logic [12:0] rem_reg [DIV_STAGES];
    logic [6:0]  q_reg   [DIV_STAGES];
    logic [5:0]  lim_reg [DIV_STAGES];
    side_t       side_reg[DIV_STAGES];

    logic [12:0] rem_in [DIV_STAGES];
    logic [6:0]  q_in   [DIV_STAGES];
    logic [5:0]  lim_in [DIV_STAGES];
    side_t       side_in[DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [12:0] lim_sh;
            // Pick up the previous stage, or the geometry for the first one
            if (k == 0)
            begin : g_first
                assign rem_in[k]        = 13'(geom.off) * 13'd100;
                assign q_in[k]          = '0;
                assign lim_in[k]        = geom.lim;
                assign side_in[k].inb   = geom.inb;
                assign side_in[k].reach = geom.reach;
                assign side_in[k].near  = geom.near;
            end
            else
            begin : g_next
                assign rem_in[k]  = rem_reg[k-1];
                assign q_in[k]    = q_reg[k-1];
                assign lim_in[k]  = lim_reg[k-1];
                assign side_in[k] = side_reg[k-1];
            end

            assign lim_sh = 13'(lim_in[k]) << (DIV_STAGES - 1 - k);

            // Trial subtract for one quotient bit
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    lim_reg[k]  <= lim_in[k];
                    side_reg[k] <= side_in[k];
                    if (rem_in[k] >= lim_sh)
                    begin
                        rem_reg[k] <= rem_in[k] - lim_sh;
                        q_reg[k]   <= q_in[k] | (7'd1 << (DIV_STAGES - 1 - k));
                    end
                    else
                    begin
                        rem_reg[k] <= rem_in[k];
                        q_reg[k]   <= q_in[k];
                    end
                end
            end
        end
    endgenerate

    assign res.inb    = side_reg[DIV_STAGES-1].inb;
    assign res.edge_q = q_reg[DIV_STAGES-1];
    assign res.reach  = side_reg[DIV_STAGES-1].reach;
    assign res.near   = side_reg[DIV_STAGES-1].near;

endmodule

// ===== hw/rtl/sbps_shade.sv =====
// Shading stages: squares of the three falloffs, scaling by 1/100, fade sum
// and grey level. Depends on sbps_pkg.
module sbps_shade (
    input  logic                                  clk,
    input  logic [sbps_pkg::SHADE_STAGES-1:0]     en,
    input  sbps_pkg::divres_t                     res,
    output logic                                  in_beam,
    output logic [3:0]                            grey_level
);
    import sbps_pkg::*;

    logic        inb1_reg, inb2_reg;
    logic [13:0] esq_reg, rsq_reg, nsq_reg;
    logic [6:0]  ed_reg, rd_reg, nd_reg;
    logic        beam_reg;
    logic [3:0]  grey_reg;

    logic [26:0] e_w, r_w, n_w;
    logic [8:0]  fade;
    logic [3:0]  level;

    // Stage 1: squares
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            inb1_reg <= res.inb;
            esq_reg  <= 14'(res.edge_q) * 14'(res.edge_q);
            rsq_reg  <= 14'(res.reach) * 14'(res.reach);
            nsq_reg  <= 14'(res.near) * 14'(res.near);
        end
    end

    // Stage 2: divide each square by 100 through a reciprocal
    always_comb
    begin
        e_w = 27'(esq_reg) * 27'd10486;
        r_w = 27'(rsq_reg) * 27'd10486;
        n_w = 27'(nsq_reg) * 27'd10486;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            inb2_reg <= inb1_reg;
            ed_reg   <= e_w[26:20];
            rd_reg   <= r_w[26:20];
            nd_reg   <= n_w[26:20];
        end
    end

    // Stage 3: fade sum, clamp and grey level
    always_comb
    begin
        fade = 9'(ed_reg) + 9'(rd_reg) + 9'(nd_reg);
        if (fade >= 9'd100)
            level = 4'd15;
        else if (fade >= 9'd50)
            level = 4'd14;
        else
            level = 4'd13;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            beam_reg <= inb2_reg;
            grey_reg <= inb2_reg ? level : 4'd0;
        end
    end

    assign in_beam    = beam_reg;
    assign grey_level = grey_reg;

endmodule

// ===== hw/rtl/sweeping_beam_pixel_shader.sv =====
// Top level of the sweeping beam pixel shader: config registers, beam angle,
// pipeline valid tracking. Depends on sbps_pkg, sbps_geom, sbps_div, sbps_shade.
//
// Usage:
//   Pixel channel: in_valid/in_ready carry pixel_x and pixel_y; one transfer
//   per pixel. Result channel: out_valid/out_ready carry in_beam and
//   grey_level, one result per pixel, in order.
//   Config channel: cfg_valid/cfg_ready write hour (index 0) or minute
//   (index 1) from cfg_data; cfg_ready is always high.
//   Throughput: one pixel per clock unless the receiver stalls or a config
//   write settles. Each pixel passes 14 register stages: 4 geometry stages, a
//   7-stage pipelined divider for the edge ratio and 3 shading stages.
//   After a config write, in_ready stays low until the settle counter runs
//   out, while the beam angle and its sine and cosine registers recompute.
//   Reset clears all valid bits and both time registers to 0.
//   When the receiver stalls, the output holds; stages behind it keep
//   advancing into empty slots, so bubbles close up before in_ready drops.
module sweeping_beam_pixel_shader (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [9:0] pixel_x,
    input  logic [8:0] pixel_y,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       in_beam,
    output logic [3:0] grey_level,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);
    import sbps_pkg::*;

    logic [4:0]              hour_reg;
    logic [5:0]              minute_reg;
    logic [7:0]              bearing_reg;
    logic signed [10:0]      ax_reg, ay_reg;
    logic [1:0]              settle_reg;
    logic [PIPE_STAGES-1:0]  valid_reg;
    logic [PIPE_STAGES-1:0]  en;

    logic [10:0]             minutes;
    logic [28:0]             bear_w;
    geom_t                   geom;
    divres_t                 dres;

    assign cfg_ready = 1'b1;

    // Config register writes; hold input off while the angle settles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg   <= '0;
            minute_reg <= '0;
            settle_reg <= '0;
        end
        else if (cfg_valid)
        begin
            settle_reg <= SETTLE_CYCLES;
            unique case (cfg_index)
                REG_HOUR:   hour_reg   <= cfg_data[4:0];
                REG_MINUTE: minute_reg <= cfg_data;
                default:    ;
            endcase
        end
        else if (settle_reg != 2'd0)
        begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // Bearing = minutes*256/1440 = minutes*8/45, by reciprocal multiply
    always_comb
    begin
        minutes = 11'(hour_reg) * 11'd60 + 11'(minute_reg);
        bear_w  = 29'({minutes, 3'b000}) * 29'd23302;
    end

    always_ff @(posedge clk)
    begin
        bearing_reg <= bear_w[27:20];
        ax_reg      <= wave_sin(bearing_reg + 8'd64);
        ay_reg      <= wave_sin(bearing_reg);
    end

    // Stage enables: a stage advances when empty or when the next one advances
    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || out_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    assign in_ready = en[0] && (settle_reg == 2'd0);

    // Advance valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid && in_ready;
            for (int i = 1; i < PIPE_STAGES; i++)
                if (en[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    assign out_valid = valid_reg[PIPE_STAGES-1];

    sbps_geom u_geom (
        .clk     (clk),
        .en      (en[GEOM_STAGES-1:0]),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .geom    (geom)
    );

    sbps_div u_div (
        .clk  (clk),
        .en   (en[GEOM_STAGES+DIV_STAGES-1:GEOM_STAGES]),
        .geom (geom),
        .res  (dres)
    );

    sbps_shade u_shade (
        .clk        (clk),
        .en         (en[PIPE_STAGES-1:GEOM_STAGES+DIV_STAGES]),
        .res        (dres),
        .in_beam    (in_beam),
        .grey_level (grey_level)
    );

endmodule

// ===== hw/rtl/sbps_checker.sv =====
// Port-level checks for the sweeping beam pixel shader, bound to the top level.
// Depends on sweeping_beam_pixel_shader's ports only.
module sbps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       in_beam,
    input logic [3:0] grey_level,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(in_beam) && $stable(grey_level))
        else $error("result changed while stalled");

    // Outside the beam the grey level is zero
    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_beam |-> grey_level == 4'd0)
        else $error("grey level set outside beam");

    // Inside the beam the grey level is 13 to 15
    a_grey_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_beam |-> grey_level == 4'd13 || grey_level == 4'd14
            || grey_level == 4'd15)
        else $error("grey level out of range");

    // Pixel input is held off right after a register write
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("pixel accepted while angle settles");

endmodule

bind sweeping_beam_pixel_shader sbps_checker u_sbps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .in_beam    (in_beam),
    .grey_level (grey_level),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);
